FILE: src/wbps_pkg.sv
// Shared types and constants for the wildcard byte pattern scanner.
package wbps_pkg;

    localparam int ADDR_W    = 48;
    localparam int BYTE_W    = 8;
    localparam int PAT_BYTES = 16;
    localparam int LEN_W     = 5;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 3;

    typedef logic [PAT_BYTES-1:0][BYTE_W-1:0] t_pat_bytes;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LOW    = 3'd0,
        CFG_PATTERN_HIGH   = 3'd1,
        CFG_CARE_MASK      = 3'd2,
        CFG_PATTERN_LENGTH = 3'd3,
        CFG_MARK_OFFSET    = 3'd4,
        CFG_START_ADDRESS  = 3'd5
    } t_cfg_idx;

    // Pattern settings that every cell sees.
    typedef struct packed {
        t_pat_bytes           pattern;
        logic [PAT_BYTES-1:0] care;
        logic [LEN_W-1:0]     len;
    } t_pat_cfg;

    // Window control from the top level to every cell.
    typedef struct packed {
        logic shift;
        logic clear;
    } t_cell_ctrl;

endpackage

FILE: src/wildcard_byte_pattern_scanner_unit.sv
// Top level of the wildcard byte pattern scanner: config registers, cell chain, result register.
//
//  channel  | direction | handshake                    | payload
//  ---------+-----------+------------------------------+-------------------------------------
//  in       | input     | i_in_valid / o_in_ready      | i_in_data_byte, i_in_last_byte
//  out      | output    | o_out_valid / i_out_ready    | o_out_found, o_out_match_address
//  cfg      | input     | i_cfg_wr_en (no wait)        | i_cfg_index, i_cfg_data
//
// One request per cycle; its result, if any, shows on the next cycle from the output register.
// The compare over all MAX_PATTERN cells and the address add fit in the single accept cycle.
// A request stalls only while the output register holds a result that is not taken.
// Synchronous active-low reset clears the window, byte index, done flag, output valid flag and config registers
module wildcard_byte_pattern_scanner_unit #(
    parameter int MAX_PATTERN = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [wbps_pkg::BYTE_W-1:0]    i_in_data_byte,
    input  logic                           i_in_last_byte,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_out_found,
    output logic [wbps_pkg::ADDR_W-1:0]    o_out_match_address,
    input  logic                           i_cfg_wr_en,
    input  logic [wbps_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [wbps_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int AW = wbps_pkg::ADDR_W;
    localparam int LW = wbps_pkg::LEN_W;

    logic [63:0]                    r_pat_low;
    logic [63:0]                    r_pat_high;
    logic [wbps_pkg::PAT_BYTES-1:0] r_care;
    logic [LW-1:0]                  r_pat_len;
    logic [LW-1:0]                  r_mark_off;
    logic [AW-1:0]                  r_start_addr;

    logic [AW-1:0]                  r_byte_index;
    logic                           r_match_done;
    logic                           r_out_valid;
    logic                           r_out_found;
    logic [AW-1:0]                  r_out_addr;

    logic [LW-1:0]                  n_len;
    logic [LW-1:0]                  len_m1;
    logic                           accept;
    logic                           filled;
    logic                           hit;
    logic                           miss_end;
    logic [5:0]                     addr_adj;
    logic [AW-1:0]                  n_addr;

    wbps_pkg::t_pat_cfg             pat_cfg;
    wbps_pkg::t_cell_ctrl           cell_ctrl;

    logic [MAX_PATTERN-1:0][wbps_pkg::BYTE_W-1:0] cell_byte;
    logic [MAX_PATTERN-1:0]                       cell_match;

    // Config writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_low    <= '0;
            r_pat_high   <= '0;
            r_care       <= '0;
            r_pat_len    <= LW'(1);
            r_mark_off   <= '0;
            r_start_addr <= '0;
        end else if (i_cfg_wr_en) begin
            case (wbps_pkg::t_cfg_idx'(i_cfg_index))
                wbps_pkg::CFG_PATTERN_LOW:    r_pat_low    <= i_cfg_data;
                wbps_pkg::CFG_PATTERN_HIGH:   r_pat_high   <= i_cfg_data;
                wbps_pkg::CFG_CARE_MASK:      r_care       <= i_cfg_data[15:0];
                wbps_pkg::CFG_PATTERN_LENGTH: r_pat_len    <= i_cfg_data[LW-1:0];
                wbps_pkg::CFG_MARK_OFFSET:    r_mark_off   <= i_cfg_data[LW-1:0];
                wbps_pkg::CFG_START_ADDRESS:  r_start_addr <= i_cfg_data[AW-1:0];
                default: ;
            endcase
        end
    end

    // Clamp length to 1..MAX_PATTERN.
    always_comb begin
        if (r_pat_len == '0) begin
            n_len = LW'(1);
        end else if (int'(r_pat_len) > MAX_PATTERN) begin
            n_len = LW'(MAX_PATTERN);
        end else begin
            n_len = r_pat_len;
        end
        len_m1 = n_len - LW'(1);
    end

    assign pat_cfg.pattern = {r_pat_high, r_pat_low};
    assign pat_cfg.care    = r_care;
    assign pat_cfg.len     = n_len;

    assign o_in_ready      = !r_out_valid || i_out_ready;
    assign accept          = i_in_valid && o_in_ready;
    assign cell_ctrl.shift = accept;
    assign cell_ctrl.clear = i_in_last_byte;

    genvar j;
    generate
        for (j = 0; j < MAX_PATTERN; j++) begin : g_cell
            logic [wbps_pkg::BYTE_W-1:0] cell_in;
            if (j == 0) begin : g_head
                assign cell_in = i_in_data_byte;
            end else begin : g_link
                assign cell_in = cell_byte[j-1];
            end
            wbps_cell #(
                .IDX (j)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctrl  (cell_ctrl),
                .i_cfg   (pat_cfg),
                .i_byte  (cell_in),
                .o_byte  (cell_byte[j]),
                .o_match (cell_match[j])
            );
        end
    endgenerate

    assign filled   = (r_byte_index >= {{(AW-LW){1'b0}}, len_m1});
    assign hit      = !r_match_done && filled && (&cell_match);
    assign miss_end = !r_match_done && !hit && i_in_last_byte;

    // Match start is index - (len-1); fold it with the mark offset into one small signed term.
    assign addr_adj = {1'b0, r_mark_off} - {1'b0, len_m1};
    assign n_addr   = r_start_addr + r_byte_index + {{(AW-6){addr_adj[5]}}, addr_adj};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_index <= '0;
            r_match_done <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (accept) begin
                if (i_in_last_byte) begin
                    r_byte_index <= '0;
                    r_match_done <= 1'b0;
                end else begin
                    r_byte_index <= r_byte_index + AW'(1);
                    r_match_done <= r_match_done || hit;
                end
                if (hit || miss_end) begin
                    r_out_valid <= 1'b1;
                end
            end
        end
    end

    // Hold result payload until a new result replaces it.
    always_ff @(posedge i_clk) begin
        if (accept && (hit || miss_end)) begin
            r_out_found <= hit;
            r_out_addr  <= hit ? n_addr : '0;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_out_found         = r_out_found;
    assign o_out_match_address = r_out_addr;

    a_not_found_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_found) |-> (o_out_match_address == '0))
        else $error("not-found result carries a nonzero address");

    a_clear_after_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in_last_byte) |=> ((r_byte_index == '0) && !r_match_done))
        else $error("region state not cleared after last byte");

    a_ready_when_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> o_in_ready)
        else $error("request stalled with empty output register");

    a_result_from_request : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !$past(o_out_valid)) |-> $past(accept))
        else $error("result appeared without an accepted request");

endmodule

FILE: src/wbps_cell.sv
// One window cell: holds a byte, passes it on, and checks the byte entering it against its pattern byte.
module wbps_cell #(
    parameter int IDX = 0
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  wbps_pkg::t_cell_ctrl        i_ctrl,
    input  wbps_pkg::t_pat_cfg          i_cfg,
    input  logic [wbps_pkg::BYTE_W-1:0] i_byte,
    output logic [wbps_pkg::BYTE_W-1:0] o_byte,
    output logic                        o_match
);

    localparam logic [6:0]                 IDX7 = 7'(IDX);
    localparam logic [wbps_pkg::LEN_W-1:0] IDX5 = wbps_pkg::LEN_W'(IDX);

    logic [wbps_pkg::BYTE_W-1:0] r_byte;
    logic                        active;
    logic [wbps_pkg::LEN_W-1:0]  k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte <= '0;
        end else if (i_ctrl.shift) begin
            r_byte <= i_ctrl.clear ? '0 : i_byte;
        end
    end

    // The byte entering this cell lines up with pattern byte len-1-IDX.
    always_comb begin
        active = ({2'b00, i_cfg.len} > IDX7);
        k      = i_cfg.len - wbps_pkg::LEN_W'(1) - IDX5;
        if (!active || k[4] || !i_cfg.care[k[3:0]]) begin
            o_match = 1'b1;
        end else begin
            o_match = (i_cfg.pattern[k[3:0]] == i_byte);
        end
    end

    assign o_byte = r_byte;

endmodule
